/* hdl/face_heading_controller_defines.svh */
// ----------------------------------------------------------------------------
// Face heading controller assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef FACE_HEADING_CONTROLLER_DEFINES_SVH
`define FACE_HEADING_CONTROLLER_DEFINES_SVH

// clocked, off while in reset
`define FHC_ASSERT(lbl, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked, also checked while in reset
`define FHC_ASSERT_ALWAYS(lbl, prop, msg) \
lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/fhc_pkg.sv */
// ----------------------------------------------------------------------------
// Face heading controller package
// Widths, angle constants, arctangent table and stage sideband types.
// ----------------------------------------------------------------------------
`default_nettype none

package fhc_pkg;

    localparam int COORD_WIDTH      = 32;
    localparam int ANGLE_FRAC_BITS  = 6;
    localparam int CORDIC_STAGES    = 16;
    localparam int TABLE_LEN        = 24;
    localparam int ZFRAC            = 20;
    localparam int PRESHIFT         = 60 - COORD_WIDTH;
    localparam int DW               = COORD_WIDTH + 1;
    localparam int XW               = 64;
    localparam int ZW               = 30;
    localparam int RSH              = ZFRAC - ANGLE_FRAC_BITS;
    localparam int HEAD_W           = 15;
    localparam int HALF_ANG         = 180 << ANGLE_FRAC_BITS;
    localparam int FULL_ANG         = 360 << ANGLE_FRAC_BITS;
    localparam int ABW              = $clog2(HALF_ANG + 1);
    localparam int EW               = ((ABW > HEAD_W) ? ABW : HEAD_W) + 2;
    localparam int RATE_W           = 16;
    localparam int CFG_AW           = 14;
    localparam int PW               = RATE_W + ABW;
    localparam int QW               = 16;
    localparam int RW               = CFG_AW + 1;
    localparam int OUT_W            = 17;
    localparam int CFG_IW           = 2;
    localparam int CFG_DW           = 16;

    typedef enum logic [CFG_IW-1:0] {
        REG_MAX_RATE  = 2'd0,
        REG_DEAD_ZONE = 2'd1,
        REG_SLOW_ZONE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic                     valid;
        logic                     zero;
        logic signed [HEAD_W-1:0] head;
    } fhc_side_t;

    typedef struct packed {
        logic valid;
        logic on;
        logic slow;
        logic neg;
    } fhc_dside_t;

    // atan(2^-i) in degrees, scaled by 2^ZFRAC
    function automatic logic signed [ZW-1:0] atan_deg(input int i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                0:  v = ZW'(47185920);
                1:  v = ZW'(27855475);
                2:  v = ZW'(14718068);
                3:  v = ZW'(7471121);
                4:  v = ZW'(3750058);
                5:  v = ZW'(1876857);
                6:  v = ZW'(938658);
                7:  v = ZW'(469357);
                8:  v = ZW'(234682);
                9:  v = ZW'(117342);
                10: v = ZW'(58671);
                11: v = ZW'(29335);
                12: v = ZW'(14668);
                13: v = ZW'(7334);
                14: v = ZW'(3667);
                15: v = ZW'(1833);
                16: v = ZW'(917);
                17: v = ZW'(458);
                18: v = ZW'(229);
                19: v = ZW'(115);
                20: v = ZW'(57);
                21: v = ZW'(29);
                22: v = ZW'(14);
                23: v = ZW'(7);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/face_heading_controller.sv */
// ----------------------------------------------------------------------------
// Face heading controller
// Bearing by pipelined CORDIC atan2, heading error wrap, dead and slow zone
// rate shaping with a pipelined divider.
//
//   channel   signals                                         direction
//   in        in_valid/in_ready, target_x/y, agent_x/y, heading  in
//   out       out_valid/out_ready, turn_rate                  out
//   cfg       cfg_valid/cfg_ready, cfg_index, cfg_data        in
//
// One word per cycle enters while the pipeline advances; its stages are input,
// pre-rotation, CORDIC stages, round, wrap, multiply, 16 divider steps, output.
// The whole pipeline advances together when the output register is empty or
// taken; a stall holds every stage. Reset clears all valid bits and loads the
// register defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module face_heading_controller
    import fhc_pkg::*;
#(
    parameter int NUM_STAGES = CORDIC_STAGES
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [31:0]   target_x,
    input  wire logic signed [31:0]   target_y,
    input  wire logic signed [31:0]   agent_x,
    input  wire logic signed [31:0]   agent_y,
    input  wire logic signed [HEAD_W-1:0] heading,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [OUT_W-1:0]   turn_rate,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IW-1:0]    cfg_index,
    input  wire logic [CFG_DW-1:0]    cfg_data
);

    localparam int NSTG = (NUM_STAGES < TABLE_LEN) ? NUM_STAGES : TABLE_LEN;

    logic                 adv;
    logic [RATE_W-1:0]    max_rate_reg;
    logic [CFG_AW-1:0]    dead_reg;
    logic [CFG_AW-1:0]    slow_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rate_reg <= RATE_W'(11520);
            dead_reg     <= CFG_AW'(128);
            slow_reg     <= CFG_AW'(1920);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_MAX_RATE:  max_rate_reg <= cfg_data[RATE_W-1:0];
                REG_DEAD_ZONE: dead_reg     <= cfg_data[CFG_AW-1:0];
                REG_SLOW_ZONE: slow_reg     <= cfg_data[CFG_AW-1:0];
                default: ;
            endcase
        end
    end

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // input stage: differences
    fhc_side_t            s0_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
        end
        else if (adv)
        begin
            s0_reg.valid <= in_valid;
            s0_reg.zero  <= 1'b0;
            s0_reg.head  <= heading;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg <= DW'($signed(target_x[COORD_WIDTH-1:0]))
                    - DW'($signed(agent_x[COORD_WIDTH-1:0]));
            dy_reg <= DW'($signed(target_y[COORD_WIDTH-1:0]))
                    - DW'($signed(agent_y[COORD_WIDTH-1:0]));
        end
    end

    // pre-rotation into the right half plane
    fhc_side_t            cs [0:NSTG];
    logic signed [XW-1:0] cx [0:NSTG];
    logic signed [XW-1:0] cy [0:NSTG];
    logic signed [ZW-1:0] cz [0:NSTG];
    fhc_side_t            s1_reg;
    logic signed [XW-1:0] x1_reg, x1_next;
    logic signed [XW-1:0] y1_reg, y1_next;
    logic signed [ZW-1:0] z1_reg, z1_next;
    logic signed [XW-1:0] xe, ye;

    always_comb
    begin
        xe = $signed({{(XW-DW){dx_reg[DW-1]}}, dx_reg}) <<< PRESHIFT;
        ye = $signed({{(XW-DW){dy_reg[DW-1]}}, dy_reg}) <<< PRESHIFT;
        if (dx_reg[DW-1])
        begin
            x1_next = -xe;
            y1_next = -ye;
            z1_next = ye[XW-1] ? -(ZW'(180) <<< ZFRAC) : (ZW'(180) <<< ZFRAC);
        end
        else
        begin
            x1_next = xe;
            y1_next = ye;
            z1_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg.valid <= s0_reg.valid;
            s1_reg.zero  <= (dx_reg == '0) && (dy_reg == '0);
            s1_reg.head  <= s0_reg.head;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg <= x1_next;
            y1_reg <= y1_next;
            z1_reg <= z1_next;
        end
    end

    assign cs[0] = s1_reg;
    assign cx[0] = x1_reg;
    assign cy[0] = y1_reg;
    assign cz[0] = z1_reg;

    for (genvar g = 0; g < NSTG; g++)
    begin : g_cordic
        fhc_cordic_stage #(.SHIFT(g)) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .side_in  (cs[g]),
            .x_in     (cx[g]),
            .y_in     (cy[g]),
            .z_in     (cz[g]),
            .side_out (cs[g+1]),
            .x_out    (cx[g+1]),
            .y_out    (cy[g+1]),
            .z_out    (cz[g+1])
        );
    end

    // round and clamp the bearing
    fhc_side_t            sr_reg;
    logic signed [EW-1:0] bear_reg, bear_next;
    logic signed [ZW-1:0] zr;

    always_comb
    begin
        zr = (cz[NSTG] + (ZW'(1) <<< (RSH - 1))) >>> RSH;
        if (zr > ZW'(HALF_ANG))
        begin
            bear_next = EW'(HALF_ANG);
        end
        else if (zr < -ZW'(HALF_ANG))
        begin
            bear_next = -EW'(HALF_ANG);
        end
        else
        begin
            bear_next = EW'(zr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_reg <= '0;
        end
        else if (adv)
        begin
            sr_reg <= cs[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bear_reg <= bear_next;
        end
    end

    // error wrap and zone decisions
    fhc_dside_t           sw_reg, sw_next;
    logic [ABW-1:0]       abs_reg, abs_next;
    logic signed [EW-1:0] err_raw, err_w;

    always_comb
    begin
        err_raw = bear_reg - EW'(sr_reg.head);
        if (err_raw > EW'(HALF_ANG))
        begin
            err_w = err_raw - EW'(FULL_ANG);
        end
        else if (err_raw < -EW'(HALF_ANG))
        begin
            err_w = err_raw + EW'(FULL_ANG);
        end
        else
        begin
            err_w = err_raw;
        end
        abs_next      = err_w[EW-1] ? ABW'(-err_w) : ABW'(err_w);
        sw_next.valid = sr_reg.valid;
        sw_next.on    = !sr_reg.zero && (EW'(abs_next) >= EW'(dead_reg));
        sw_next.slow  = EW'(abs_next) < EW'(slow_reg);
        sw_next.neg   = !(err_w > 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= '0;
        end
        else if (adv)
        begin
            sw_reg <= sw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            abs_reg <= abs_next;
        end
    end

    // scale by the maximum rate
    fhc_dside_t    sm_reg;
    logic [PW-1:0] prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_reg <= '0;
        end
        else if (adv)
        begin
            sm_reg <= sw_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= PW'(max_rate_reg) * PW'(abs_reg);
        end
    end

    // divide by the slow zone
    fhc_dside_t    ds  [0:QW];
    logic [RW-1:0] drem [0:QW];
    logic [QW-1:0] dlow [0:QW];

    assign ds[0]   = sm_reg;
    assign drem[0] = RW'(prod_reg >> QW);
    assign dlow[0] = prod_reg[QW-1:0];

    for (genvar d = 0; d < QW; d++)
    begin : g_div
        fhc_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .divisor  (slow_reg),
            .side_in  (ds[d]),
            .rem_in   (drem[d]),
            .low_in   (dlow[d]),
            .side_out (ds[d+1]),
            .rem_out  (drem[d+1]),
            .low_out  (dlow[d+1])
        );
    end

    // output register
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] rate_reg, rate_next;
    logic [RATE_W-1:0]       mag;

    always_comb
    begin
        mag = ds[QW].slow ? RATE_W'(dlow[QW]) : max_rate_reg;
        if (!ds[QW].on)
        begin
            rate_next = '0;
        end
        else if (ds[QW].neg)
        begin
            rate_next = -$signed({1'b0, mag});
        end
        else
        begin
            rate_next = $signed({1'b0, mag});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ds[QW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rate_reg <= rate_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign turn_rate = rate_reg;

endmodule

`default_nettype wire

/* hdl/fhc_cordic_stage.sv */
// ----------------------------------------------------------------------------
// CORDIC vectoring stage
// One registered micro-rotation toward the x axis with angle accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module fhc_cordic_stage
    import fhc_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire fhc_side_t            side_in,
    input  wire logic signed [XW-1:0] x_in,
    input  wire logic signed [XW-1:0] y_in,
    input  wire logic signed [ZW-1:0] z_in,
    output fhc_side_t                 side_out,
    output logic signed [XW-1:0]      x_out,
    output logic signed [XW-1:0]      y_out,
    output logic signed [ZW-1:0]      z_out
);

    localparam logic signed [ZW-1:0] ANG = atan_deg(SHIFT);

    fhc_side_t            side_reg;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [XW-1:0] xs, ys;

    always_comb
    begin
        xs = x_in >>> SHIFT;
        ys = y_in >>> SHIFT;
        if (!y_in[XW-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ANG;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (adv)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign side_out = side_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

endmodule

`default_nettype wire

/* hdl/fhc_div_stage.sv */
// ----------------------------------------------------------------------------
// Divider stage
// One restoring long-division step, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fhc_div_stage
    import fhc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic [CFG_AW-1:0] divisor,
    input  wire fhc_dside_t        side_in,
    input  wire logic [RW-1:0]     rem_in,
    input  wire logic [QW-1:0]     low_in,
    output fhc_dside_t             side_out,
    output logic [RW-1:0]          rem_out,
    output logic [QW-1:0]          low_out
);

    fhc_dside_t      side_reg;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]   low_reg, low_next;
    logic [RW-1:0]   cand;
    logic            qbit;

    always_comb
    begin
        cand     = {rem_in[RW-2:0], low_in[QW-1]};
        qbit     = (cand >= RW'(divisor));
        rem_next = qbit ? (cand - RW'(divisor)) : cand;
        low_next = {low_in[QW-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (adv)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign side_out = side_reg;
    assign rem_out  = rem_reg;
    assign low_out  = low_reg;

endmodule

`default_nettype wire

/* hdl/fhc_checker.sv */
// ----------------------------------------------------------------------------
// Face heading controller checker
// Port-level checks on flow control, reset and the turn rate range.
// ----------------------------------------------------------------------------
`default_nettype none

`include "face_heading_controller_defines.svh"

module fhc_checker
    import fhc_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic signed [OUT_W-1:0] turn_rate,
    input wire logic                    cfg_ready
);

    `FHC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(turn_rate), "word dropped")
    `FHC_ASSERT(a_in_ready, in_ready == (!out_valid || out_ready), "input ready not tied to output")
    `FHC_ASSERT(a_rate_range, out_valid |-> turn_rate != -(OUT_W'(65536)), "rate out of range")
    `FHC_ASSERT(a_cfg_ready, cfg_ready, "config not ready")
    `FHC_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "output valid in reset")

endmodule

bind face_heading_controller fhc_checker u_fhc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .turn_rate (turn_rate),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Face heading controller testbench
// Drives target, agent and heading words through the valid/ready input,
// predicts each turn rate with a local CORDIC bearing and zone shaping, and
// checks every result in order under several idle and stall patterns and
// register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import fhc_pkg::*;

    localparam int LATENCY   = CORDIC_STAGES + 22;
    localparam int CYCLE_CAP = 2000000;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [31:0]        target_x;
    logic signed [31:0]        target_y;
    logic signed [31:0]        agent_x;
    logic signed [31:0]        agent_y;
    logic signed [HEAD_W-1:0]  heading;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [OUT_W-1:0]   turn_rate;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IW-1:0]         cfg_index;
    logic [CFG_DW-1:0]         cfg_data;

    logic [15:0]               rate_max;
    logic [13:0]               dead_zone;
    logic [13:0]               slow_zone;

    logic signed [OUT_W-1:0]   rate_queue[$];
    int                        send_idle_pct;
    int                        recv_stall_pct;
    int                        hold_off;
    int                        fail_count;
    int                        rate_count;
    int                        item_count;
    longint                    cycles;

    face_heading_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .target_x  (target_x),
        .target_y  (target_y),
        .agent_x   (agent_x),
        .agent_y   (agent_y),
        .heading   (heading),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .turn_rate (turn_rate),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_step(int i);
        longint t[24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                          938658, 469357, 234682, 117342, 58671, 29335, 14668,
                          7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
        return t[i];
    endfunction

    function automatic longint bearing_of(longint dx, longint dy);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint a;
        longint lim;
        x = dx <<< PRESHIFT;
        y = dy <<< PRESHIFT;
        z = 0;
        lim = longint'(HALF_ANG);
        if (x < 0)
        begin
            z = (y >= 0) ? (longint'(180) <<< ZFRAC) : -(longint'(180) <<< ZFRAC);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end
        end
        a = floor_shift(z + (longint'(1) <<< (RSH - 1)), RSH);
        if (a > lim)
            a = lim;
        if (a < -lim)
            a = -lim;
        return a;
    endfunction

    function automatic logic signed [OUT_W-1:0] turn_rate_of(
        logic signed [31:0] tx, logic signed [31:0] ty,
        logic signed [31:0] ax, logic signed [31:0] ay,
        logic signed [HEAD_W-1:0] hd);
        longint dx;
        longint dy;
        longint err;
        longint abs_err;
        longint mag;
        longint rate;
        dx = longint'(tx) - longint'(ax);
        dy = longint'(ty) - longint'(ay);
        rate = 0;
        if (dx != 0 || dy != 0)
        begin
            err = bearing_of(dx, dy) - longint'(hd);
            while (err > HALF_ANG)
                err -= FULL_ANG;
            while (err < -HALF_ANG)
                err += FULL_ANG;
            abs_err = (err < 0) ? -err : err;
            if (abs_err >= dead_zone)
            begin
                if (abs_err < slow_zone)
                    mag = (longint'(rate_max) * abs_err) / longint'(slow_zone);
                else
                    mag = rate_max;
                rate = (err > 0) ? mag : -mag;
            end
        end
        return OUT_W'(rate);
    endfunction

    task automatic idle_cycle();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_word(logic signed [31:0] tx, logic signed [31:0] ty,
                             logic signed [31:0] ax, logic signed [31:0] ay,
                             logic signed [HEAD_W-1:0] hd);
        while ($urandom_range(99) < send_idle_pct)
            idle_cycle();
        in_valid <= 1'b1;
        target_x <= tx;
        target_y <= ty;
        agent_x  <= ax;
        agent_y  <= ay;
        heading  <= hd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rate_queue.push_back(turn_rate_of(tx, ty, ax, ay, hd));
        item_count++;
        @(negedge clk);
    endtask

    task automatic drain();
        while (rate_queue.size() != 0)
            idle_cycle();
        repeat (LATENCY + 4) idle_cycle();
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MAX_RATE:  rate_max  = value;
            REG_DEAD_ZONE: dead_zone = value[13:0];
            REG_SLOW_ZONE: slow_zone = value[13:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_zones(logic [15:0] mx, logic [13:0] dz, logic [13:0] sz);
        drain();
        write_reg(REG_MAX_RATE, mx);
        write_reg(REG_DEAD_ZONE, CFG_DW'(dz));
        write_reg(REG_SLOW_ZONE, CFG_DW'(sz));
    endtask

    function automatic logic signed [HEAD_W-1:0] rand_heading();
        if ($urandom_range(9) == 0)
            return HEAD_W'($urandom);
        return HEAD_W'($signed($urandom_range(2 * HALF_ANG)) - HALF_ANG);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(2000)) - 1000;
            2: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
            default: return $signed($urandom_range(65535)) - 32768;
        endcase
    endfunction

    task automatic send_random();
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [HEAD_W-1:0] hd;
        ax = rand_coord();
        ay = rand_coord();
        tx = ($urandom_range(30) == 0) ? ax : ax + rand_coord();
        ty = ($urandom_range(30) == 0) ? ay : ay + rand_coord();
        if ($urandom_range(4) == 0)
        begin
            tx = rand_coord();
            ty = rand_coord();
        end
        hd = rand_heading();
        if ($urandom_range(3) == 0)
            hd = HEAD_W'(bearing_of(longint'(tx) - longint'(ax),
                                    longint'(ty) - longint'(ay))
                 + $signed($urandom_range(2 * slow_zone + 4)) - slow_zone - 2);
        send_word(tx, ty, ax, ay, hd);
    endtask

    task automatic test_directed();
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        send_word(0, 0, 0, 0, 0);
        send_word(mx, mx, mx, mx, HEAD_W'(HALF_ANG));
        send_word(mx, 0, mn, 0, 0);
        send_word(mn, 0, mx, 0, 0);
        send_word(0, mx, 0, mn, 0);
        send_word(0, mn, 0, mx, 0);
        send_word(mx, mx, mn, mn, -HEAD_W'(HALF_ANG));
        send_word(mn, mn, mx, mx, HEAD_W'(HALF_ANG));
        send_word(-256, 0, 0, 0, 0);
        send_word(-256, -1, 0, 0, HEAD_W'(HALF_ANG));
        send_word(-256, 1, 0, 0, -HEAD_W'(HALF_ANG));
        send_word(256, 0, 0, 0, 100);
        send_word(256, 0, 0, 0, 127);
        send_word(256, 0, 0, 0, 128);
        send_word(256, 0, 0, 0, 1919);
        send_word(256, 0, 0, 0, 1920);
        send_word(256, 0, 0, 0, -1000);
        send_word(256, 256, 0, 0, 14'sh3fff);
        send_word(256, 256, 0, 0, 15'sh4000);
        send_word(-256, 256, 0, 0, 15'sh7fff);
        send_word(0, 1, 0, 0, 0);
        send_word(1, -1, 0, 0, 0);
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 200;
        repeat (120) send_random();
        while (hold_off != 0)
            idle_cycle();
        drain();
        repeat (20) send_random();
    endtask

    task automatic test_register_extremes();
        set_zones(16'hffff, 14'd0, 14'd1);
        test_random(80, 0, 0);
        set_zones(16'd0, 14'd11520, 14'd11520);
        test_random(60, 14, 14);
        set_zones(16'hffff, 14'd0, 14'd11520);
        test_random(120, 0, 0);
        set_zones(16'd777, 14'd300, 14'd100);
        test_random(80, 14, 14);
        set_zones(16'd11520, 14'd128, 14'd1920);
    endtask

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off  <= hold_off - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        logic signed [OUT_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            rate_count++;
            if (rate_queue.size() == 0)
            begin
                $error("turn_rate: unexpected word %0d", turn_rate);
                fail_count++;
            end
            else
            begin
                want = rate_queue.pop_front();
                if (turn_rate !== want)
                begin
                    $error("turn_rate: expected %0d, actual %0d", want, turn_rate);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("face_heading_controller regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        target_x = '0;
        target_y = '0;
        agent_x = '0;
        agent_y = '0;
        heading = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAX_RATE;
        cfg_data = '0;
        rate_max = 16'd11520;
        dead_zone = 14'd128;
        slow_zone = 14'd1920;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        fail_count = 0;
        rate_count = 0;
        item_count = 0;
        cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(300, 0, 0);
        test_random(300, 82, 0);
        test_random(300, 0, 82);
        test_random(300, 14, 14);
        test_backpressure();
        test_register_extremes();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        $display("Sent %0d words, checked %0d turn rates across idle, stall and",
                 item_count, rate_count);
        $display("register-extreme phases, with %0d mismatches.", fail_count);
        if (fail_count == 0 && rate_queue.size() == 0)
            $display("face_heading_controller regression: pass");
        else
            $display("face_heading_controller regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
